// ----- sv/wsp_pkg.sv -----
package wsp_pkg;

    typedef enum logic [4:0] {
        P_COUNT, P_DONE,
        P_TAG, P_PCNT, P_PARAM, P_RCNT, P_RES,
        P_MODLEN, P_MODSKIP, P_NAMELEN, P_NAMESKIP, P_DKIND, P_DIDX,
        P_TIDX,
        P_REF, P_LFLAG, P_MIN, P_MAX,
        P_VTYPE, P_MUT, P_INIT
    } t_phase;

    localparam logic [4:0] K_COUNT   = 5'd0;
    localparam logic [4:0] K_PCNT    = 5'd1;
    localparam logic [4:0] K_PTYPE   = 5'd2;
    localparam logic [4:0] K_RCNT    = 5'd3;
    localparam logic [4:0] K_RTYPE   = 5'd4;
    localparam logic [4:0] K_MODLEN  = 5'd5;
    localparam logic [4:0] K_NAMELEN = 5'd6;
    localparam logic [4:0] K_DKIND   = 5'd7;
    localparam logic [4:0] K_DIDX    = 5'd8;
    localparam logic [4:0] K_TIDX    = 5'd9;
    localparam logic [4:0] K_REF     = 5'd10;
    localparam logic [4:0] K_MIN     = 5'd11;
    localparam logic [4:0] K_MAX     = 5'd12;
    localparam logic [4:0] K_VTYPE   = 5'd13;
    localparam logic [4:0] K_MUT     = 5'd14;
    localparam logic [4:0] K_INIT    = 5'd15;
    localparam logic [4:0] K_START   = 5'd16;
    localparam logic [4:0] K_NONE    = 5'd17;

    localparam logic [2:0] S_OK   = 3'd0;
    localparam logic [2:0] S_LEB  = 3'd1;
    localparam logic [2:0] S_TAG  = 3'd2;
    localparam logic [2:0] S_DESC = 3'd3;
    localparam logic [2:0] S_LIM  = 3'd4;
    localparam logic [2:0] S_MUT  = 3'd5;
    localparam logic [2:0] S_REF  = 3'd6;
    localparam logic [2:0] S_LEN  = 3'd7;

    localparam logic [2:0] SEC_TYPE   = 3'd0;
    localparam logic [2:0] SEC_IMPORT = 3'd1;
    localparam logic [2:0] SEC_FUNC   = 3'd2;
    localparam logic [2:0] SEC_TABLE  = 3'd3;
    localparam logic [2:0] SEC_MEMORY = 3'd4;
    localparam logic [2:0] SEC_GLOBAL = 3'd5;
    localparam logic [2:0] SEC_EXPORT = 3'd6;
    localparam logic [2:0] SEC_START  = 3'd7;

    localparam logic [7:0] REF_EXTERN = 8'h6F;
    localparam logic [7:0] REF_FUNC   = 8'h70;
    localparam logic [7:0] FUNC_TAG   = 8'h60;
    localparam logic [7:0] END_OP     = 8'h0B;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [4:0]  record_kind;
        logic [31:0] entry_number;
        logic [31:0] record_value;
        logic [31:0] value_offset;
        logic [2:0]  parse_status;
        logic        section_done;
    } t_out;

    typedef struct packed {
        logic        done;
        logic        bad;
        logic [31:0] accum;
        logic [2:0]  nbytes;
    } t_leb;

endpackage

// ----- sv/wsp_leb.sv -----
module wsp_leb
    import wsp_pkg::*;
(
    input  logic [31:0] i_accum,
    input  logic [2:0]  i_nbytes,
    input  logic [7:0]  i_byte,
    output t_leb        o_leb
);
    logic [31:0] base;
    logic [31:0] group;

    always_comb begin
        base  = (i_nbytes == 3'd0) ? 32'd0 : i_accum;
        case (i_nbytes)
            3'd0:    group = {25'd0, i_byte[6:0]};
            3'd1:    group = {18'd0, i_byte[6:0], 7'd0};
            3'd2:    group = {11'd0, i_byte[6:0], 14'd0};
            3'd3:    group = {4'd0, i_byte[6:0], 21'd0};
            default: group = {i_byte[3:0], 28'd0};
        endcase
        o_leb.bad    = (i_nbytes >= 3'd4) && (i_byte[7:4] != 4'd0);
        o_leb.done   = !o_leb.bad && !i_byte[7];
        o_leb.accum  = o_leb.bad ? base : (base | group);
        if (o_leb.bad || !i_byte[7]) begin
            o_leb.nbytes = 3'd0;
        end else if (i_nbytes >= 3'd4) begin
            o_leb.nbytes = 3'd5;
        end else begin
            o_leb.nbytes = i_nbytes + 3'd1;
        end
    end
endmodule

// ----- sv/wasm_section_parser.sv -----
// WebAssembly section body parser. Feed the body one byte per transaction with
// last_byte on the final one; set the section kind beforehand through the
// config port, which also restarts the parser. The parser registers and the
// decode of one byte sit in front of a single result register, so a byte is
// taken every cycle while that register is empty or being emptied. Records
// come for each completed field but the tag and limits flag, for the first
// error, and for the final byte (section_done set) if no error came first.
module wasm_section_parser
    import wsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data
);
    logic [2:0]  r_kind;
    t_phase      r_phase, n_phase;
    logic [31:0] r_leb_accum, n_leb_accum;
    logic [2:0]  r_leb_bytes, n_leb_bytes;
    logic [31:0] r_entries, n_entries;
    logic [31:0] r_entry_cnt, n_entry_cnt;
    logic [31:0] r_inner, n_inner;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_start, n_start;
    logic        r_failed, n_failed;
    logic        r_out_valid;
    t_out        r_out;

    logic        accept;
    logic        emit;
    logic [7:0]  b;
    logic        last;
    logic [4:0]  rk;
    logic [31:0] rv;
    logic [31:0] ro;
    logic [2:0]  st;
    logic [31:0] entry_out;
    t_leb        lr;

    wsp_leb u_leb (
        .i_accum  (r_leb_accum),
        .i_nbytes (r_leb_bytes),
        .i_byte   (i_data.section_byte),
        .o_leb    (lr)
    );

    function automatic t_phase entry_phase(input logic [31:0] left, input logic [2:0] kind);
        t_phase p;
        if (left == 32'd0) begin
            p = P_DONE;
        end else begin
            case (kind)
                SEC_TYPE:   p = P_TAG;
                SEC_IMPORT: p = P_MODLEN;
                SEC_FUNC:   p = P_TIDX;
                SEC_TABLE:  p = P_REF;
                SEC_MEMORY: p = P_LFLAG;
                SEC_GLOBAL: p = P_VTYPE;
                SEC_EXPORT: p = P_NAMELEN;
                default:    p = P_DONE;
            endcase
        end
        return p;
    endfunction

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign b       = i_data.section_byte;
    assign last    = i_data.last_byte;

    always_comb begin
        n_phase     = r_phase;
        n_leb_accum = r_leb_accum;
        n_leb_bytes = r_leb_bytes;
        n_entries   = r_entries;
        n_entry_cnt = r_entry_cnt;
        n_inner     = r_inner;
        n_start     = r_start;
        n_failed    = r_failed;
        emit        = 1'b0;
        rk          = K_NONE;
        rv          = 32'd0;
        ro          = 32'd0;
        st          = S_OK;

        if (!r_failed) begin
            case (r_phase)
                P_COUNT, P_PCNT, P_RCNT, P_MODLEN, P_NAMELEN, P_DIDX, P_TIDX,
                P_MIN, P_MAX: begin
                    n_leb_accum = lr.accum;
                    n_leb_bytes = lr.nbytes;
                    if (lr.bad) begin
                        st = S_LEB;
                    end else if (lr.done) begin
                        emit = 1'b1;
                        rv   = lr.accum;
                        case (r_phase)
                            P_COUNT: begin
                                if (r_kind == SEC_START) begin
                                    rk      = K_START;
                                    n_phase = P_DONE;
                                end else begin
                                    rk          = K_COUNT;
                                    n_entries   = lr.accum;
                                    n_entry_cnt = 32'd0;
                                    n_phase     = entry_phase(lr.accum, r_kind);
                                end
                            end
                            P_PCNT: begin
                                rk      = K_PCNT;
                                n_inner = lr.accum;
                                n_phase = (lr.accum != 32'd0) ? P_PARAM : P_RCNT;
                            end
                            P_MODLEN, P_NAMELEN: begin
                                n_inner = lr.accum;
                                n_start = r_pos + 32'd1;
                                ro      = r_pos + 32'd1;
                                if (r_phase == P_MODLEN) begin
                                    rk      = K_MODLEN;
                                    n_phase = (lr.accum != 32'd0) ? P_MODSKIP : P_NAMELEN;
                                end else begin
                                    rk      = K_NAMELEN;
                                    n_phase = (lr.accum != 32'd0) ? P_NAMESKIP : P_DKIND;
                                end
                            end
                            P_MIN: begin
                                rk = K_MIN;
                                if (r_inner != 32'd0) begin
                                    n_phase = P_MAX;
                                end else begin
                                    n_entries   = r_entries - 32'd1;
                                    n_entry_cnt = r_entry_cnt + 32'd1;
                                    n_phase     = entry_phase(r_entries - 32'd1, r_kind);
                                end
                            end
                            P_RCNT: begin
                                rk      = K_RCNT;
                                n_inner = lr.accum;
                                if (lr.accum != 32'd0) begin
                                    n_phase = P_RES;
                                end else begin
                                    n_entries   = r_entries - 32'd1;
                                    n_entry_cnt = r_entry_cnt + 32'd1;
                                    n_phase     = entry_phase(r_entries - 32'd1, r_kind);
                                end
                            end
                            default: begin
                                // descriptor index, type index, limits max
                                case (r_phase)
                                    P_DIDX:  rk = K_DIDX;
                                    P_TIDX:  rk = K_TIDX;
                                    default: rk = K_MAX;
                                endcase
                                n_entries   = r_entries - 32'd1;
                                n_entry_cnt = r_entry_cnt + 32'd1;
                                n_phase     = entry_phase(r_entries - 32'd1, r_kind);
                            end
                        endcase
                    end
                end
                P_TAG: begin
                    if (b != FUNC_TAG) st = S_TAG;
                    else n_phase = P_PCNT;
                end
                P_PARAM, P_RES: begin
                    emit    = 1'b1;
                    rv      = {24'd0, b};
                    n_inner = r_inner - 32'd1;
                    if (r_phase == P_PARAM) begin
                        rk = K_PTYPE;
                        if (r_inner == 32'd1) n_phase = P_RCNT;
                    end else begin
                        rk = K_RTYPE;
                        if (r_inner == 32'd1) begin
                            n_entries   = r_entries - 32'd1;
                            n_entry_cnt = r_entry_cnt + 32'd1;
                            n_phase     = entry_phase(r_entries - 32'd1, r_kind);
                        end
                    end
                end
                P_MODSKIP: begin
                    n_inner = r_inner - 32'd1;
                    if (r_inner == 32'd1) n_phase = P_NAMELEN;
                end
                P_NAMESKIP: begin
                    n_inner = r_inner - 32'd1;
                    if (r_inner == 32'd1) n_phase = P_DKIND;
                end
                P_DKIND: begin
                    if (b > 8'd3) begin
                        st = S_DESC;
                    end else begin
                        emit    = 1'b1;
                        rk      = K_DKIND;
                        rv      = {24'd0, b};
                        n_phase = P_DIDX;
                    end
                end
                P_REF: begin
                    if (b != REF_EXTERN && b != REF_FUNC) begin
                        st = S_REF;
                    end else begin
                        emit    = 1'b1;
                        rk      = K_REF;
                        rv      = {24'd0, b};
                        n_phase = P_LFLAG;
                    end
                end
                P_LFLAG: begin
                    if (b > 8'd1) begin
                        st = S_LIM;
                    end else begin
                        n_inner = {24'd0, b};
                        n_phase = P_MIN;
                    end
                end
                P_VTYPE: begin
                    emit    = 1'b1;
                    rk      = K_VTYPE;
                    rv      = {24'd0, b};
                    n_phase = P_MUT;
                end
                P_MUT: begin
                    if (b > 8'd1) begin
                        st = S_MUT;
                    end else begin
                        emit    = 1'b1;
                        rk      = K_MUT;
                        rv      = {24'd0, b};
                        n_start = r_pos + 32'd1;
                        n_phase = P_INIT;
                    end
                end
                P_INIT: begin
                    if (b == END_OP) begin
                        emit        = 1'b1;
                        rk          = K_INIT;
                        rv          = r_pos - r_start + 32'd1;
                        ro          = r_start;
                        n_entries   = r_entries - 32'd1;
                        n_entry_cnt = r_entry_cnt + 32'd1;
                        n_phase     = entry_phase(r_entries - 32'd1, r_kind);
                    end
                end
                default: begin
                    st = S_LEN;
                end
            endcase

            if (st != S_OK) begin
                rk       = K_NONE;
                rv       = 32'd0;
                ro       = 32'd0;
                emit     = 1'b1;
                n_failed = 1'b1;
            end
            if (last) begin
                if (st == S_OK && n_phase != P_DONE) st = S_LEN;
                emit = 1'b1;
            end
        end

        // entry number is taken before the end-of-section restart
        entry_out = n_entry_cnt;

        n_pos = r_pos + 32'd1;
        if (last) begin
            n_phase     = P_COUNT;
            n_leb_accum = 32'd0;
            n_leb_bytes = 3'd0;
            n_entries   = 32'd0;
            n_entry_cnt = 32'd0;
            n_inner     = 32'd0;
            n_pos       = 32'd0;
            n_start     = 32'd0;
            n_failed    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_kind      <= i_rst_n ? i_cfg_data : SEC_TYPE;
            r_phase     <= P_COUNT;
            r_leb_accum <= 32'd0;
            r_leb_bytes <= 3'd0;
            r_entries   <= 32'd0;
            r_entry_cnt <= 32'd0;
            r_inner     <= 32'd0;
            r_pos       <= 32'd0;
            r_start     <= 32'd0;
            r_failed    <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_leb_accum <= n_leb_accum;
            r_leb_bytes <= n_leb_bytes;
            r_entries   <= n_entries;
            r_entry_cnt <= n_entry_cnt;
            r_inner     <= n_inner;
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_failed    <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out.record_kind  <= rk;
            r_out.entry_number <= entry_out;
            r_out.record_value <= rv;
            r_out.value_offset <= ro;
            r_out.parse_status <= st;
            r_out.section_done <= last;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.section_done && o_data.parse_status == S_OK
        |-> o_data.record_kind != K_NONE)
        else $error("ok final record without a field");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.parse_status != S_OK && o_data.parse_status != S_LEN
        |-> o_data.record_kind == K_NONE)
        else $error("error record carries a field kind");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

// ----- test/wsp_checker.sv -----
module wsp_checker
    import wsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic       i_valid,
    input  logic       i_in_ready,
    input  t_in        i_data,
    input  logic       i_out_valid,
    input  logic       i_ready,
    input  t_out       i_out,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]  kind;
    t_phase      ph;
    logic [31:0] acc, left, entry, inner, pos, fstart;
    logic [2:0]  nb;
    logic        dead;
    t_out        records[$];

    assign o_pending = records.size();

    task automatic clear_parser();
        ph = P_COUNT; acc = 0; nb = 0; left = 0; entry = 0;
        inner = 0; pos = 0; fstart = 0; dead = 0;
    endtask

    // 0 more bytes, 1 done, 2 malformed
    function automatic int leb_step(input logic [7:0] b);
        logic [2:0] k;
        k = nb;
        if (k == 0) acc = 0;
        if (k >= 4) begin
            if (b[7:4] != 0) begin
                nb = 0;
                return 2;
            end
            k = 4;
        end
        acc |= 32'(b[6:0]) << (7 * k);
        if (b[7]) begin
            nb = k + 1;
            return 0;
        end
        nb = 0;
        return 1;
    endfunction

    task automatic open_entry();
        if (left == 0) begin
            ph = P_DONE;
            return;
        end
        case (kind)
            SEC_TYPE: ph = P_TAG;
            SEC_IMPORT: ph = P_MODLEN;
            SEC_FUNC: ph = P_TIDX;
            SEC_TABLE: ph = P_REF;
            SEC_MEMORY: ph = P_LFLAG;
            SEC_GLOBAL: ph = P_VTYPE;
            SEC_EXPORT: ph = P_NAMELEN;
            default: ph = P_DONE;
        endcase
    endtask

    task automatic close_entry();
        left -= 1;
        entry += 1;
        open_entry();
    endtask

    task automatic decode_byte(input t_in d);
        logic [7:0]  b;
        logic [4:0]  rk;
        logic [31:0] rv, ro;
        logic [2:0]  st;
        logic        emit;
        int          r;
        t_out        rec;
        b = d.section_byte; rk = K_NONE; rv = 0; ro = 0; st = S_OK; emit = 0;
        if (dead) begin
            if (d.last_byte) clear_parser(); else pos += 1;
            return;
        end
        case (ph)
            P_COUNT: begin
                r = leb_step(b);
                if (r == 2) st = S_LEB;
                else if (r == 1) begin
                    emit = 1; rv = acc;
                    if (kind == SEC_START) begin
                        rk = K_START; ph = P_DONE;
                    end else begin
                        rk = K_COUNT; left = acc; entry = 0; open_entry();
                    end
                end
            end
            P_DONE: st = S_LEN;
            P_TAG: if (b != FUNC_TAG) st = S_TAG; else ph = P_PCNT;
            P_PCNT, P_RCNT: begin
                r = leb_step(b);
                if (r == 2) st = S_LEB;
                else if (r == 1) begin
                    emit = 1; rv = acc; inner = acc;
                    if (ph == P_PCNT) begin
                        rk = K_PCNT; ph = inner != 0 ? P_PARAM : P_RCNT;
                    end else begin
                        rk = K_RCNT;
                        if (inner != 0) ph = P_RES; else close_entry();
                    end
                end
            end
            P_PARAM: begin
                emit = 1; rk = K_PTYPE; rv = b; inner -= 1;
                if (inner == 0) ph = P_RCNT;
            end
            P_RES: begin
                emit = 1; rk = K_RTYPE; rv = b; inner -= 1;
                if (inner == 0) close_entry();
            end
            P_MODLEN, P_NAMELEN: begin
                r = leb_step(b);
                if (r == 2) st = S_LEB;
                else if (r == 1) begin
                    emit = 1; rv = acc; inner = acc;
                    fstart = pos + 1; ro = fstart;
                    if (ph == P_MODLEN) begin
                        rk = K_MODLEN; ph = inner != 0 ? P_MODSKIP : P_NAMELEN;
                    end else begin
                        rk = K_NAMELEN; ph = inner != 0 ? P_NAMESKIP : P_DKIND;
                    end
                end
            end
            P_MODSKIP: begin
                inner -= 1;
                if (inner == 0) ph = P_NAMELEN;
            end
            P_NAMESKIP: begin
                inner -= 1;
                if (inner == 0) ph = P_DKIND;
            end
            P_DKIND: begin
                if (b > 3) st = S_DESC;
                else begin
                    emit = 1; rk = K_DKIND; rv = b; ph = P_DIDX;
                end
            end
            P_DIDX, P_TIDX: begin
                r = leb_step(b);
                if (r == 2) st = S_LEB;
                else if (r == 1) begin
                    emit = 1; rv = acc; rk = ph == P_DIDX ? K_DIDX : K_TIDX;
                    close_entry();
                end
            end
            P_REF: begin
                if (b != REF_EXTERN && b != REF_FUNC) st = S_REF;
                else begin
                    emit = 1; rk = K_REF; rv = b; ph = P_LFLAG;
                end
            end
            P_LFLAG: begin
                if (b > 1) st = S_LIM;
                else begin
                    inner = b; ph = P_MIN;
                end
            end
            P_MIN, P_MAX: begin
                r = leb_step(b);
                if (r == 2) st = S_LEB;
                else if (r == 1) begin
                    emit = 1; rv = acc;
                    if (ph == P_MIN) begin
                        rk = K_MIN;
                        if (inner != 0) ph = P_MAX; else close_entry();
                    end else begin
                        rk = K_MAX; close_entry();
                    end
                end
            end
            P_VTYPE: begin
                emit = 1; rk = K_VTYPE; rv = b; ph = P_MUT;
            end
            P_MUT: begin
                if (b > 1) st = S_MUT;
                else begin
                    emit = 1; rk = K_MUT; rv = b; fstart = pos + 1; ph = P_INIT;
                end
            end
            P_INIT: begin
                if (b == END_OP) begin
                    emit = 1; rk = K_INIT; rv = pos - fstart + 1; ro = fstart;
                    close_entry();
                end
            end
            default: st = S_LEN;
        endcase
        if (st != S_OK) begin
            rk = K_NONE; rv = 0; ro = 0; emit = 1; dead = 1;
        end
        if (d.last_byte) begin
            if (st == S_OK && ph != P_DONE) st = S_LEN;
            emit = 1;
        end
        if (!emit) begin
            pos += 1;
            return;
        end
        rec.record_kind = rk; rec.entry_number = entry; rec.record_value = rv;
        rec.value_offset = ro; rec.parse_status = st; rec.section_done = d.last_byte;
        records.push_back(rec);
        if (d.last_byte) clear_parser(); else pos += 1;
    endtask

    always @(posedge i_clk) begin
        t_out exp_rec;
        if (!i_rst_n) begin
            kind = SEC_TYPE;
            clear_parser();
            records.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && i_ready) begin
                if (records.size() == 0) begin
                    $display("%0t unexpected record %p", $time, i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_rec = records.pop_front();
                    if (exp_rec !== i_out) begin
                        $display("%0t mismatch expected %p actual %p", $time, exp_rec, i_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready) decode_byte(i_data);
            if (i_cfg_we) begin
                kind = i_cfg_data;
                clear_parser();
            end
        end
    end
endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import wsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic i_clk = 0, i_rst_n = 0, i_cfg_we = 0, i_valid = 0, i_ready = 0;
    logic [2:0] i_cfg_data = 0;
    logic o_ready, o_valid;
    t_in  i_data = '0;
    t_out o_data;
    int   errors, pending, idle_cycles = 0;
    int   bytes_sent = 0;
    logic [7:0] body[$];

    always #4 i_clk = ~i_clk;

    wasm_section_parser dut (.*);

    wsp_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .i_in_ready(o_ready),
        .i_data, .i_out_valid(o_valid), .i_ready, .i_out(o_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: stalls in runs of varying density
    always @(posedge i_clk) begin
        int mode;
        mode = ($time / 3000) % 4;
        case (mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 3) != 0;
            2: i_ready <= $urandom_range(0, 1);
            default: i_ready <= $urandom_range(0, 7) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic put_leb(input logic [31:0] v);
        do begin
            body.push_back({v > 127, v[6:0]});
            v >>= 7;
        end while (v != 0);
    endtask

    // occasionally a padded or malformed 5-byte form
    task automatic put_field(input logic [31:0] v);
        int c;
        c = $urandom_range(0, 19);
        if (c == 0) begin
            body.push_back(8'h80 | v[6:0]); body.push_back(8'h80 | v[13:7]);
            body.push_back(8'h80 | v[20:14]); body.push_back(8'h80 | v[27:21]);
            body.push_back({4'h0, v[31:28]});
        end else if (c == 1) begin
            repeat (4) body.push_back(8'h80 | 8'($urandom));
            body.push_back(8'($urandom_range(16, 255)));
        end else put_leb(v);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 127);
            2: return $urandom_range(0, 20000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick(input logic [7:0] good, input logic [7:0] bad);
        return $urandom_range(0, 24) == 0 ? bad : good;
    endfunction

    task automatic build_section(input logic [2:0] sec);
        int n;
        body.delete();
        n = $urandom_range(0, 4);
        if (sec == SEC_START) begin
            put_field(rnd_val());
            return;
        end
        put_field(n);
        for (int e = 0; e < n; e++) begin
            int a, m;
            case (sec)
                SEC_TYPE: begin
                    body.push_back(pick(FUNC_TAG, 8'($urandom)));
                    a = $urandom_range(0, 3); put_field(a);
                    repeat (a) body.push_back(8'($urandom));
                    a = $urandom_range(0, 2); put_field(a);
                    repeat (a) body.push_back(8'($urandom));
                end
                SEC_IMPORT, SEC_EXPORT: begin
                    if (sec == SEC_IMPORT) begin
                        a = $urandom_range(0, 4); put_field(a);
                        repeat (a) body.push_back(8'($urandom));
                    end
                    a = $urandom_range(0, 4); put_field(a);
                    repeat (a) body.push_back(8'($urandom));
                    body.push_back(pick(8'($urandom_range(0, 3)),
                                        8'($urandom_range(4, 255))));
                    put_field(rnd_val());
                end
                SEC_FUNC: put_field(rnd_val());
                SEC_TABLE, SEC_MEMORY: begin
                    if (sec == SEC_TABLE)
                        body.push_back(pick($urandom_range(0, 1) ? REF_FUNC : REF_EXTERN,
                                            8'($urandom)));
                    m = $urandom_range(0, 1);
                    body.push_back(pick(8'(m), 8'($urandom_range(2, 255))));
                    put_field(rnd_val());
                    if (m) put_field(rnd_val());
                end
                SEC_GLOBAL: begin
                    body.push_back(8'($urandom));
                    body.push_back(pick(8'($urandom_range(0, 1)),
                                        8'($urandom_range(2, 255))));
                    a = $urandom_range(0, 4);
                    repeat (a) begin
                        m = $urandom;
                        body.push_back(m == END_OP ? 8'h41 : 8'(m));
                    end
                    body.push_back(END_OP);
                end
                default: ;
            endcase
        end
        // early end or trailing bytes now and then
        case ($urandom_range(0, 11))
            0: if (body.size() > 1) void'(body.pop_back());
            1: body.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{section_byte: b, last_byte: last};
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_body();
        foreach (body[i]) send_byte(body[i], i == body.size() - 1);
        i_valid <= 1'b0;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_kind(input logic [2:0] k);
        i_cfg_we <= 1'b1; i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: type section with extremes and tag error
        body = '{8'h02, 8'h60, 8'h01, 8'h7F, 8'h01, 8'h00,
                 8'h60, 8'h00, 8'h00};
        send_body();
        body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F}; send_body();
        body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'h00}; send_body();
        body = '{8'h01, 8'h5F, 8'h00}; send_body();
        settle();
        set_kind(SEC_START);
        body = '{8'h80, 8'h01}; send_body();
        body = '{8'h05, 8'h00}; send_body();
        settle();
        set_kind(SEC_GLOBAL);
        body = '{8'h01, 8'h7F, 8'h00, 8'h41, 8'h00}; send_body();
        body = '{8'h01, 8'h7F, 8'h02, 8'h0B}; send_body();
        settle();

        // random sections, each round's kind drawn at random from all eight kinds
        while (bytes_sent < 815) begin
            set_kind($urandom_range(0, 7));
            repeat ($urandom_range(1, 4)) begin
                build_section(i_cfg_data);
                send_body();
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/wsp_pkg.sv
sv/wsp_leb.sv
sv/wasm_section_parser.sv
test/wsp_checker.sv
test/tb_top.sv
